@@ src/lsal_pkg.sv @@
// ----------------------------------------------------------------------------
// lsal_pkg: shared types and constants for the auto-ranging lux block
// outcome codes, sequencer states, register indexes, datapath widths and
// the gain and integration time denominator table
// ----------------------------------------------------------------------------
package lsal_pkg;

    // field widths
    localparam int COUNT_W = 16;
    localparam int SEL_W   = 3;
    localparam int CPL_W   = 12;
    localparam int GAIN_W  = 2;
    localparam int RETRY_W = 3;
    localparam int LUX_W   = 40;
    localparam int CONF_W  = 7;

    localparam int MAX_RETRIES = 4;

    // lux numerator in hundredths, positive part only
    localparam int N_W    = 23;
    localparam int PROD_W = N_W + CPL_W;
    localparam int FRAC_W = 20;
    localparam int NUM_W  = PROD_W + FRAC_W;
    localparam int DEN_W  = 30;
    localparam int CNT_W  = $clog2(NUM_W);

    localparam logic [LUX_W-1:0] LUX_FLOOR_Q = 40'd105;
    localparam logic [LUX_W-1:0] LOWLIGHT_LIMIT_Q = 40'd1049;
    localparam int LL_Q_W   = 11;
    // 92 times ceil(2^24 / 100): exact floor(q * 92 / 100) for small q
    localparam logic [23:0] LOWLIGHT_MUL = 24'd15435116;
    localparam int LL_SHIFT = 24;
    localparam int LL_PROD_W = LL_Q_W + LL_SHIFT;

    localparam logic [GAIN_W-1:0] GAIN_MAX  = 2'd3;
    localparam logic [GAIN_W-1:0] GAIN_MIN  = 2'd0;
    localparam logic [SEL_W-1:0]  SEL_LONGEST = 3'd5;

    // register reset values
    localparam logic [SEL_W-1:0]   RST_INTEG_SEL = 3'd5;
    localparam logic [COUNT_W-1:0] RST_SAT_LEVEL = 16'd65535;
    localparam logic [COUNT_W-1:0] RST_MIN_SIG   = 16'd100;
    localparam logic [COUNT_W-1:0] RST_DARK      = 16'd0;
    localparam logic [CPL_W-1:0]   RST_CPL       = 12'd408;

    typedef enum logic [2:0] {
        OUTCOME_ACCEPT    = 3'd0,
        OUTCOME_RETRY     = 3'd1,
        OUTCOME_SAT_LOW   = 3'd2,
        OUTCOME_INVALID   = 3'd3,
        OUTCOME_EXHAUSTED = 3'd4
    } outcome_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MULT,
        ST_DIV,
        ST_CORR,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        REG_INTEG_SEL = 3'd0,
        REG_SAT_LEVEL = 3'd1,
        REG_MIN_SIG   = 3'd2,
        REG_DARK      = 3'd3,
        REG_CPL       = 3'd4
    } reg_idx_t;

    // 100 * ms * gain multiplier, ms = 100 * (sel + 1)
    function automatic logic [DEN_W-1:0] denom_of(logic [SEL_W-1:0] sel,
                                                  logic [GAIN_W-1:0] gain);
        logic [26:0] base;
        logic [30:0] prod;
        unique case (gain)
            2'd0: base = 27'd10000;
            2'd1: base = 27'd250000;
            2'd2: base = 27'd4280000;
            2'd3: base = 27'd98760000;
            default: base = 27'd10000;
        endcase
        prod = 31'(base) * 31'({1'b0, sel} + 4'd1);
        return prod[DEN_W-1:0];
    endfunction

endpackage

@@ src/light_sensor_autorange_lux.sv @@
// ----------------------------------------------------------------------------
// light_sensor_autorange_lux: auto-ranging two-channel lux engine
// decides gain moves and retries per reading, and on accept computes
// dark-corrected lux in Q20.20 with a bit-serial divider and a confidence
// ----------------------------------------------------------------------------
//
// channel  | dir | ports                      | content
// ---------+-----+----------------------------+--------------------------------
// reading  | in  | s_tvalid s_tready s_tdata  | full count, ir count,
//          |     | s_tuser                    | tuser = reading valid bit
// result   | out | m_tvalid m_tready m_tdata  | gain, lux Q20.20, confidence,
//          |     | m_tuser                    | tuser = outcome code
// config   | in  | psel penable pwrite paddr  | five registers at 4 * index
//          |     | pwdata prdata pready       |
//
// sequence: an accepted reading goes through decide, multiply, 55 divider
//   steps one quotient bit each, correction, result load, and the idle state
//   that takes the next request; a reading that ends without lux goes from
//   decide straight to result load; the divider is a restoring divider
// one request in flight; s_tready is high only while the sequencer is idle
// the result register lets a new request in while the old result waits;
//   a finished request waits in its last step until that register is free
// reset is synchronous active low: sequencer, retry count and result valid
//   are cleared, gain goes to max, configuration registers take reset values
//
module light_sensor_autorange_lux (
    input  logic        aclk,
    input  logic        aresetn,
    // reading request
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] full_count, [31:16] ir_count
    input  logic [0:0]  s_tuser,   // [0] data_valid
    // result request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [1:0] gain_level, [41:2] lux_value,
                                   // [48:42] confidence, [55:49] zero
    output logic [2:0]  m_tuser,   // [2:0] outcome
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [lsal_pkg::SEL_W-1:0]   integ_sel_reg;
    logic [lsal_pkg::COUNT_W-1:0] sat_level_reg;
    logic [lsal_pkg::COUNT_W-1:0] min_sig_reg;
    logic [lsal_pkg::COUNT_W-1:0] dark_reg;
    logic [lsal_pkg::CPL_W-1:0]   cpl_reg;
    lsal_pkg::reg_idx_t           reg_idx;
    logic                         cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = lsal_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_sel_reg <= lsal_pkg::RST_INTEG_SEL;
            sat_level_reg <= lsal_pkg::RST_SAT_LEVEL;
            min_sig_reg   <= lsal_pkg::RST_MIN_SIG;
            dark_reg      <= lsal_pkg::RST_DARK;
            cpl_reg       <= lsal_pkg::RST_CPL;
        end else if (cfg_wr) begin
            // indexes beyond the list are dropped
            unique case (reg_idx)
                lsal_pkg::REG_INTEG_SEL: integ_sel_reg <= pwdata[lsal_pkg::SEL_W-1:0];
                lsal_pkg::REG_SAT_LEVEL: sat_level_reg <= pwdata[lsal_pkg::COUNT_W-1:0];
                lsal_pkg::REG_MIN_SIG:   min_sig_reg   <= pwdata[lsal_pkg::COUNT_W-1:0];
                lsal_pkg::REG_DARK:      dark_reg      <= pwdata[lsal_pkg::COUNT_W-1:0];
                lsal_pkg::REG_CPL:       cpl_reg       <= pwdata[lsal_pkg::CPL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            lsal_pkg::REG_INTEG_SEL: prdata = 32'(integ_sel_reg);
            lsal_pkg::REG_SAT_LEVEL: prdata = 32'(sat_level_reg);
            lsal_pkg::REG_MIN_SIG:   prdata = 32'(min_sig_reg);
            lsal_pkg::REG_DARK:      prdata = 32'(dark_reg);
            lsal_pkg::REG_CPL:       prdata = 32'(cpl_reg);
            default:                 prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer and handshake control
    // ------------------------------------------------------------------
    lsal_pkg::state_t state_reg, state_next;
    logic             in_take;
    logic             load_out;
    logic             div_last;
    logic [lsal_pkg::CNT_W-1:0] cnt_reg;
    logic             m_valid_reg;

    lsal_pkg::outcome_t eval_outcome;

    assign in_take  = s_tvalid && s_tready;
    assign div_last = (cnt_reg == lsal_pkg::CNT_W'(lsal_pkg::NUM_W - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lsal_pkg::ST_IDLE: if (s_tvalid) state_next = lsal_pkg::ST_EVAL;
            lsal_pkg::ST_EVAL: begin
                // only an accepted reading needs the lux path
                if (eval_outcome == lsal_pkg::OUTCOME_ACCEPT) begin
                    state_next = lsal_pkg::ST_MULT;
                end else begin
                    state_next = lsal_pkg::ST_FIN;
                end
            end
            lsal_pkg::ST_MULT: state_next = lsal_pkg::ST_DIV;
            lsal_pkg::ST_DIV:  if (div_last) state_next = lsal_pkg::ST_CORR;
            lsal_pkg::ST_CORR: state_next = lsal_pkg::ST_FIN;
            lsal_pkg::ST_FIN:  if (!m_valid_reg || m_tready) state_next = lsal_pkg::ST_IDLE;
            default:           state_next = lsal_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == lsal_pkg::ST_IDLE);
        load_out = (state_reg == lsal_pkg::ST_FIN) && (!m_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsal_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // input capture
    // ------------------------------------------------------------------
    logic [lsal_pkg::COUNT_W-1:0] full_reg;
    logic [lsal_pkg::COUNT_W-1:0] ir_reg;
    logic                         valid_reg;

    always_ff @(posedge aclk) begin
        if (in_take) begin
            full_reg  <= s_tdata[15:0];
            ir_reg    <= s_tdata[31:16];
            valid_reg <= s_tuser[0];
        end
    end

    // ------------------------------------------------------------------
    // decision: gain move, retry count, outcome
    // ------------------------------------------------------------------
    logic [lsal_pkg::GAIN_W-1:0]  gain_reg, eval_gain;
    logic [lsal_pkg::RETRY_W-1:0] retry_reg, eval_retry;
    logic                         saturated;
    logic                         low_sig;
    logic                         do_retry;

    assign saturated = (full_reg >= sat_level_reg) || (ir_reg >= sat_level_reg);
    assign low_sig   = (full_reg < min_sig_reg) && (gain_reg != lsal_pkg::GAIN_MAX);

    always_comb begin
        eval_gain    = gain_reg;
        eval_retry   = '0;
        eval_outcome = lsal_pkg::OUTCOME_ACCEPT;
        do_retry     = 1'b0;
        priority if (!valid_reg) begin
            eval_outcome = lsal_pkg::OUTCOME_INVALID;
        end else if (saturated) begin
            if (gain_reg == lsal_pkg::GAIN_MIN) begin
                eval_outcome = lsal_pkg::OUTCOME_SAT_LOW;
            end else begin
                eval_gain = gain_reg - 2'd1;
                do_retry  = 1'b1;
            end
        end else if (low_sig) begin
            eval_gain = gain_reg + 2'd1;
            do_retry  = 1'b1;
        end else begin
            eval_outcome = lsal_pkg::OUTCOME_ACCEPT;
        end
        if (do_retry) begin
            if (retry_reg < lsal_pkg::RETRY_W'(lsal_pkg::MAX_RETRIES)) begin
                eval_outcome = lsal_pkg::OUTCOME_RETRY;
                eval_retry   = retry_reg + 3'd1;
            end else begin
                eval_outcome = lsal_pkg::OUTCOME_EXHAUSTED;
                eval_retry   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg  <= lsal_pkg::GAIN_MAX;
            retry_reg <= '0;
        end else if (state_reg == lsal_pkg::ST_EVAL) begin
            gain_reg  <= eval_gain;
            retry_reg <= eval_retry;
        end
    end

    // ------------------------------------------------------------------
    // dark correction, dual formula, confidence
    // ------------------------------------------------------------------
    logic [lsal_pkg::COUNT_W-1:0] f_corr, i_corr;
    logic [25:0]                  n1, n2, n_max;
    logic [lsal_pkg::N_W-1:0]     n_pos;
    logic [22:0]                  ir_x100, full_x35, full_x25;
    logic [lsal_pkg::CONF_W-1:0]  conf_calc;

    always_comb begin
        f_corr = (full_reg > dark_reg) ? full_reg - dark_reg : '0;
        i_corr = (ir_reg > dark_reg) ? ir_reg - dark_reg : '0;
        // hundredths, two's complement in 26 bits
        n1 = 26'(f_corr) * 26'd100 - 26'(i_corr) * 26'd164;
        n2 = 26'(f_corr) * 26'd59 - 26'(i_corr) * 26'd86;
        n_max = ($signed(n1) > $signed(n2)) ? n1 : n2;
        // a non-positive numerator divides to zero and takes the floor
        n_pos = ($signed(n_max) > 26'sd0) ? n_max[lsal_pkg::N_W-1:0] : '0;
    end

    always_comb begin
        ir_x100  = 23'(ir_reg) * 23'd100;
        full_x35 = 23'(full_reg) * 23'd35;
        full_x25 = 23'(full_reg) * 23'd25;
        conf_calc = 7'd100;
        if (full_reg < 16'd50) begin
            conf_calc = conf_calc - 7'd30;
        end else if (full_reg < 16'd200) begin
            conf_calc = conf_calc - 7'd15;
        end
        if (full_reg > 16'd60000) begin
            conf_calc = conf_calc - 7'd20;
        end
        if (full_reg != '0) begin
            if (ir_x100 > full_x35) begin
                conf_calc = conf_calc - 7'd25;
            end else if (ir_x100 > full_x25) begin
                conf_calc = conf_calc - 7'd10;
            end
        end
    end

    // ------------------------------------------------------------------
    // lux datapath: product, bit-serial restoring divide, floor, low light
    // ------------------------------------------------------------------
    lsal_pkg::outcome_t                res_outcome_reg;
    logic [lsal_pkg::CONF_W-1:0]       conf_reg;
    logic [lsal_pkg::N_W-1:0]          n_reg;
    logic [lsal_pkg::DEN_W-1:0]        den_reg;
    logic [lsal_pkg::NUM_W-1:0]        num_reg;
    logic [lsal_pkg::DEN_W-1:0]        rem_reg;
    logic [lsal_pkg::LUX_W-1:0]        quo_reg;
    logic                              ovf_reg;
    logic [lsal_pkg::LUX_W-1:0]        q_fl_reg;
    logic                              ll_reg;
    logic [lsal_pkg::LL_PROD_W-1:0]    ll_prod_reg;

    logic [lsal_pkg::PROD_W-1:0]       prod;
    logic [lsal_pkg::DEN_W:0]          partial, diff;
    logic                              q_bit;
    logic [lsal_pkg::LUX_W-1:0]        q_raw, q_fl;
    logic                              ll_hit;
    logic [lsal_pkg::LUX_W-1:0]        lux_res;

    always_comb begin
        prod    = lsal_pkg::PROD_W'(n_reg) * lsal_pkg::PROD_W'(cpl_reg);
        // shift in the next numerator bit, try to subtract the divisor
        partial = {rem_reg, num_reg[lsal_pkg::NUM_W-1]};
        diff    = partial - {1'b0, den_reg};
        q_bit   = (partial >= {1'b0, den_reg});
        // quotient bits above the 40-bit field saturate the result
        q_raw   = ovf_reg ? '1 : quo_reg;
        q_fl    = (q_raw < lsal_pkg::LUX_FLOOR_Q) ? lsal_pkg::LUX_FLOOR_Q : q_raw;
        ll_hit  = (q_fl < lsal_pkg::LOWLIGHT_LIMIT_Q) && (gain_reg == lsal_pkg::GAIN_MAX)
                  && (integ_sel_reg == lsal_pkg::SEL_LONGEST);
        if (res_outcome_reg != lsal_pkg::OUTCOME_ACCEPT) begin
            lux_res = '0;
        end else if (ll_reg) begin
            lux_res = lsal_pkg::LUX_W'(ll_prod_reg[lsal_pkg::LL_PROD_W-1:lsal_pkg::LL_SHIFT]);
        end else begin
            lux_res = q_fl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            lsal_pkg::ST_EVAL: begin
                res_outcome_reg <= eval_outcome;
                conf_reg        <= (eval_outcome == lsal_pkg::OUTCOME_ACCEPT) ? conf_calc : '0;
                n_reg           <= n_pos;
                den_reg         <= lsal_pkg::denom_of(integ_sel_reg, eval_gain);
            end
            lsal_pkg::ST_MULT: begin
                num_reg <= {prod, {lsal_pkg::FRAC_W{1'b0}}};
                rem_reg <= '0;
                quo_reg <= '0;
                ovf_reg <= 1'b0;
                cnt_reg <= '0;
            end
            lsal_pkg::ST_DIV: begin
                num_reg <= num_reg << 1;
                rem_reg <= q_bit ? diff[lsal_pkg::DEN_W-1:0] : partial[lsal_pkg::DEN_W-1:0];
                quo_reg <= {quo_reg[lsal_pkg::LUX_W-2:0], q_bit};
                ovf_reg <= ovf_reg | quo_reg[lsal_pkg::LUX_W-1];
                cnt_reg <= cnt_reg + 1'b1;
            end
            lsal_pkg::ST_CORR: begin
                q_fl_reg    <= q_fl;
                ll_reg      <= ll_hit;
                ll_prod_reg <= lsal_pkg::LL_PROD_W'(q_fl[lsal_pkg::LL_Q_W-1:0])
                               * lsal_pkg::LL_PROD_W'(lsal_pkg::LOWLIGHT_MUL);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    lsal_pkg::outcome_t           out_outcome_reg;
    logic [lsal_pkg::GAIN_W-1:0]  out_gain_reg;
    logic [lsal_pkg::LUX_W-1:0]   out_lux_reg;
    logic [lsal_pkg::CONF_W-1:0]  out_conf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_outcome_reg <= res_outcome_reg;
            out_gain_reg    <= gain_reg;
            out_lux_reg     <= lux_res;
            out_conf_reg    <= conf_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_conf_reg, out_lux_reg, out_gain_reg};
    assign m_tuser  = out_outcome_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_retry_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        retry_reg <= lsal_pkg::RETRY_W'(lsal_pkg::MAX_RETRIES))
        else $error("retry count above limit");

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == lsal_pkg::ST_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (out_outcome_reg != lsal_pkg::OUTCOME_ACCEPT))
        |-> (out_lux_reg == '0) && (out_conf_reg == '0))
        else $error("failed measurement carries lux or confidence");

    a_take_to_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> (state_reg == lsal_pkg::ST_EVAL))
        else $error("accepted request did not start evaluation");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> (state_reg != lsal_pkg::ST_IDLE)
        || $past(state_reg) != lsal_pkg::ST_FIN)
        else $error("result loaded over a waiting result");

endmodule

@@ sim/light_sensor_autorange_lux_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_sensor_autorange_lux_test: self-checking bench for the lux engine
// directed and random readings under several register settings, a bench-side
// model of gain, retry, lux and confidence predicts and checks every result
// ----------------------------------------------------------------------------
module light_sensor_autorange_lux_test;

    localparam int NUM_PHASES   = 10;
    localparam int DRAIN_CYCLES = 70;     // longer than one full accept
    localparam int STALL_LIMIT  = 4000;   // cycles without any request moving

    // one reading as the bench sees it
    typedef struct packed {
        logic [15:0] full;
        logic [15:0] ir;
        logic        valid;
    } reading_t;

    // one predicted result
    typedef struct {
        lsal_pkg::outcome_t outcome;
        logic [1:0]         gain;
        logic [39:0]        lux;
        logic [6:0]         conf;
    } lux_result_t;

    // kinds of random reading
    typedef enum int {
        RK_INVALID,
        RK_SAT,
        RK_WEAK,
        RK_DIM,
        RK_GENERAL
    } reading_kind_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // reading request
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;

    // result request
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;

    // configuration port
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // bench copy of the registers and the sequencer state
    logic [2:0]  sel_cfg  = lsal_pkg::RST_INTEG_SEL;
    logic [15:0] sat_cfg  = lsal_pkg::RST_SAT_LEVEL;
    logic [15:0] min_cfg  = lsal_pkg::RST_MIN_SIG;
    logic [15:0] dark_cfg = lsal_pkg::RST_DARK;
    logic [11:0] cpl_cfg  = lsal_pkg::RST_CPL;
    logic [1:0]  gain_q   = lsal_pkg::GAIN_MAX;
    logic [2:0]  retry_q  = '0;

    reading_t    reading_queue [$];   // readings waiting to be driven
    lux_result_t lux_expected  [$];   // predicted results, oldest first

    int  outstanding   = 0;           // readings queued whose result has not come
    int  errors        = 0;
    int  readings_sent = 0;
    int  stall_cycles  = 0;
    int  outcome_seen [0:4] = '{default: 0};
    logic no_idle = 1'b0;             // one phase runs without any idling
    logic s_fire  = 1'b0;             // reading request taken at the last rising edge

    light_sensor_autorange_lux dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // next-state and result of one reading, advances the bench state
    function automatic lux_result_t predict_reading(reading_t rd);
        lux_result_t res;
        logic        moved;
        logic [15:0] f;
        logic [15:0] i;
        longint      n1;
        longint      n2;
        longint      n;
        logic [63:0] mult;
        logic [63:0] den;
        logic [63:0] prod;
        logic [63:0] q;
        int unsigned c;
        int unsigned full_u;
        int unsigned ir_u;
        res.outcome = lsal_pkg::OUTCOME_ACCEPT;
        res.lux     = '0;
        res.conf    = '0;
        moved       = 1'b0;
        if (!rd.valid) begin
            res.outcome = lsal_pkg::OUTCOME_INVALID;
            retry_q     = '0;
        end else if (rd.full >= sat_cfg || rd.ir >= sat_cfg) begin
            // saturated: step the gain down, or give up at the lowest gain
            if (gain_q == lsal_pkg::GAIN_MIN) begin
                res.outcome = lsal_pkg::OUTCOME_SAT_LOW;
                retry_q     = '0;
            end else begin
                gain_q = gain_q - 2'd1;
                moved  = 1'b1;
            end
        end else if (rd.full < min_cfg && gain_q != lsal_pkg::GAIN_MAX) begin
            // low signal: step the gain up
            gain_q = gain_q + 2'd1;
            moved  = 1'b1;
        end else begin
            retry_q = '0;
            // dark correction clamped at zero
            f  = (rd.full > dark_cfg) ? rd.full - dark_cfg : 16'd0;
            i  = (rd.ir > dark_cfg) ? rd.ir - dark_cfg : 16'd0;
            // both formulas in hundredths, larger one wins
            n1 = 100 * longint'(f) - 164 * longint'(i);
            n2 = 59 * longint'(f) - 86 * longint'(i);
            n  = (n1 > n2) ? n1 : n2;
            case (gain_q)
                2'd0:    mult = 64'd1;
                2'd1:    mult = 64'd25;
                2'd2:    mult = 64'd428;
                default: mult = 64'd9876;
            endcase
            den = 64'd10000 * (64'(sel_cfg) + 64'd1) * mult;
            if (n <= 0) begin
                q = 64'(lsal_pkg::LUX_FLOOR_Q);
            end else begin
                prod = n;
                prod = prod * 64'(cpl_cfg);
                q    = (prod << 20) / den;
                if (q < 64'(lsal_pkg::LUX_FLOOR_Q)) begin
                    q = 64'(lsal_pkg::LUX_FLOOR_Q);
                end
            end
            // low-light correction at max gain and longest integration
            if (q < 64'(lsal_pkg::LOWLIGHT_LIMIT_Q) && gain_q == lsal_pkg::GAIN_MAX
                && sel_cfg == lsal_pkg::SEL_LONGEST) begin
                q = q * 64'd92 / 64'd100;
            end
            if (q > 64'hFF_FFFF_FFFF) begin
                q = 64'hFF_FFFF_FFFF;
            end
            res.lux = q[39:0];
            // confidence from the raw counts
            full_u = 32'(rd.full);
            ir_u   = 32'(rd.ir);
            c      = 100;
            if (full_u < 50) begin
                c = c - 30;
            end else if (full_u < 200) begin
                c = c - 15;
            end
            if (full_u > 60000) begin
                c = c - 20;
            end
            if (full_u > 0) begin
                if (100 * ir_u > 35 * full_u) begin
                    c = c - 25;
                end else if (100 * ir_u > 25 * full_u) begin
                    c = c - 10;
                end
            end
            res.conf = c[6:0];
        end
        if (moved) begin
            if (retry_q < 3'(lsal_pkg::MAX_RETRIES)) begin
                retry_q     = retry_q + 3'd1;
                res.outcome = lsal_pkg::OUTCOME_RETRY;
            end else begin
                retry_q     = '0;
                res.outcome = lsal_pkg::OUTCOME_EXHAUSTED;
            end
        end
        res.gain = gain_q;
        return res;
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endfunction

    // infrared count around the ratio thresholds, or anywhere
    function automatic logic [15:0] ir_for(logic [15:0] full);
        int unsigned pick;
        int unsigned b;
        int unsigned v;
        pick = $urandom_range(9);
        if (pick < 2) begin
            v = $urandom_range(65535);
        end else if (pick < 6) begin
            b = (pick < 4) ? 25 : 35;
            v = (32'(full) * b + 99) / 100 + $urandom_range(2);
            v = (v > 0) ? v - 1 : 0;
        end else begin
            v = 32'(full) * $urandom_range(100) / 100;
        end
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic reading_t make_reading(reading_kind_t kind);
        reading_t    rd;
        int unsigned hi;
        rd.full  = 16'($urandom);
        rd.ir    = 16'($urandom);
        rd.valid = 1'b1;
        hi       = (sat_cfg != 16'd0) ? 32'(sat_cfg) - 32'd1 : 32'd0;
        case (kind)
            RK_INVALID: rd.valid = 1'b0;
            RK_SAT: begin
                if ($urandom_range(1)) begin
                    rd.full = 16'($urandom_range(65535, 32'(sat_cfg)));
                end else begin
                    rd.ir = 16'($urandom_range(65535, 32'(sat_cfg)));
                end
            end
            RK_WEAK: begin
                if (min_cfg != 16'd0) begin
                    rd.full = 16'($urandom_range(32'(min_cfg) - 32'd1, 0));
                end
                rd.ir = ir_for(rd.full);
            end
            RK_DIM: begin
                rd.full = 16'($urandom_range(300));
                rd.ir   = ir_for(rd.full);
            end
            default: begin
                if ($urandom_range(3) == 0) begin
                    rd.full = 16'($urandom_range(65535, 59990));
                end else if (32'(min_cfg) <= hi) begin
                    rd.full = 16'($urandom_range(hi, 32'(min_cfg)));
                end
                rd.ir = ir_for(rd.full);
            end
        endcase
        return rd;
    endfunction

    task automatic send_reading(reading_t rd);
        reading_queue.push_back(rd);
        outstanding++;
        readings_sent++;
    endtask

    // register write then read back, updates the bench copy
    task automatic write_reg(lsal_pkg::reg_idx_t idx, logic [31:0] value);
        logic [31:0] stored;
        case (idx)
            lsal_pkg::REG_INTEG_SEL: begin
                sel_cfg = value[2:0];
                stored  = {29'd0, value[2:0]};
            end
            lsal_pkg::REG_SAT_LEVEL: begin
                sat_cfg = value[15:0];
                stored  = {16'd0, value[15:0]};
            end
            lsal_pkg::REG_MIN_SIG: begin
                min_cfg = value[15:0];
                stored  = {16'd0, value[15:0]};
            end
            lsal_pkg::REG_DARK: begin
                dark_cfg = value[15:0];
                stored   = {16'd0, value[15:0]};
            end
            default: begin
                cpl_cfg = value[11:0];
                stored  = {20'd0, value[11:0]};
            end
        endcase
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        // read setup right after the write access
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        check_field("register readback", 64'(stored), 64'(prdata));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // all five registers, now and then with junk in the unused upper bits
    task automatic set_registers(logic [2:0] sel, logic [15:0] sat, logic [15:0] mins,
                                 logic [15:0] dark, logic [11:0] cpl);
        logic [31:0] junk;
        junk = ($urandom_range(3) == 0) ? $urandom : 32'd0;
        write_reg(lsal_pkg::REG_INTEG_SEL, {junk[31:3], sel});
        write_reg(lsal_pkg::REG_SAT_LEVEL, {junk[31:16], sat});
        write_reg(lsal_pkg::REG_MIN_SIG, {junk[31:16], mins});
        write_reg(lsal_pkg::REG_DARK, {junk[31:16], dark});
        write_reg(lsal_pkg::REG_CPL, {junk[31:12], cpl});
    endtask

    // wait for every result, then let the sequencer settle
    task automatic drain();
        while (outstanding != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // reading driver: new request only once the current one has been taken
    always @(negedge aclk) begin : reading_driver
        reading_t rd;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (reading_queue.size() != 0 && (no_idle || $urandom_range(99) >= 11)) begin
                rd = reading_queue.pop_front();
                s_tdata  <= {rd.ir, rd.full};
                s_tuser  <= rd.valid;
                s_tvalid <= 1'b1;
            end else begin
                // idle bus carries junk the block must ignore
                s_tdata  <= $urandom;
                s_tuser  <= 1'($urandom_range(1));
                s_tvalid <= 1'b0;
            end
        end
        // result side back-pressure
        m_tready <= aresetn && (no_idle || $urandom_range(99) >= 11);
    end

    // monitor: check each result request, predict each reading request
    always @(posedge aclk) begin : result_monitor
        lux_result_t want;
        reading_t    rd;
        s_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (lux_expected.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected, expected none, actual %0h / %0h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = lux_expected.pop_front();
                    outstanding--;
                    check_field("outcome", 64'(want.outcome), 64'(m_tuser));
                    check_field("gain_level", 64'(want.gain), 64'(m_tdata[1:0]));
                    check_field("lux_value", 64'(want.lux), 64'(m_tdata[41:2]));
                    check_field("confidence", 64'(want.conf), 64'(m_tdata[48:42]));
                    check_field("tdata pad", 64'd0, 64'(m_tdata[55:49]));
                    outcome_seen[int'(want.outcome)]++;
                end
            end
            if (s_tvalid && s_tready) begin
                rd.full  = s_tdata[15:0];
                rd.ir    = s_tdata[31:16];
                rd.valid = s_tuser[0];
                lux_expected.push_back(predict_reading(rd));
            end
        end
    end

    // watchdog: no request moving while work is outstanding
    always @(posedge aclk) begin : watchdog
        if (outstanding > 0 && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            stall_cycles++;
        end else begin
            stall_cycles = 0;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, stall_cycles);
            $display("light_sensor_autorange_lux verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int            phase;
        int            k;
        int            j;
        int            len;
        int            count;
        int unsigned   pick;
        reading_kind_t kind;

        // reset at the start, once
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed readings under reset values: gain walks from max down and back
        send_reading({16'd0,     16'd0,     1'b1});  // dark accept at max gain, low-light
        send_reading({16'd0,     16'd0,     1'b0});  // invalid
        send_reading({16'd65535, 16'd0,     1'b1});  // full saturated, gain down
        send_reading({16'd65535, 16'd65535, 1'b1});  // both saturated
        send_reading({16'd0,     16'd65535, 1'b1});  // ir saturated, reaches lowest gain
        send_reading({16'd65535, 16'd100,   1'b1});  // saturated at lowest gain
        send_reading({16'd50,    16'd10,    1'b1});  // low signal, gain up
        send_reading({16'd10,    16'd0,     1'b1});
        send_reading({16'd10,    16'd0,     1'b1});  // back at max gain
        send_reading({16'd10,    16'd3,     1'b1});  // low but max gain: accept, low-light
        send_reading({16'd65535, 16'd0,     1'b1});  // alternate moves until retries run out
        send_reading({16'd0,     16'd0,     1'b1});
        send_reading({16'd65535, 16'd0,     1'b1});
        send_reading({16'd0,     16'd0,     1'b1});
        send_reading({16'd65535, 16'd0,     1'b1});  // retries exhausted
        send_reading({16'd60001, 16'd21001, 1'b1});  // bright and ir heavy
        send_reading({16'd200,   16'd50,    1'b1});  // ratio exactly at the lower bound
        send_reading({16'd199,   16'd50,    1'b1});  // just below 200, ratio just above
        send_reading({16'd1000,  16'd351,   1'b1});  // ratio just above the upper bound
        send_reading({16'd1000,  16'd0,     1'b0});  // invalid at mid gain
        send_reading({16'd65534, 16'd65534, 1'b1});  // one below saturation
        send_reading({16'd1000,  16'd650,   1'b1});  // second formula wins
        send_reading({16'd1000,  16'd700,   1'b1});  // both formulas negative, floor
        send_reading({16'd49,    16'd0,     1'b1});  // low signal
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                // shortest integration, biggest scale: lux clamps at the top
                0: set_registers(3'd0, 16'd65535, 16'd0, 16'd0, 12'd4095);
                // everything saturates, dark offset at its maximum
                1: set_registers(3'd7, 16'd0, 16'd65535, 16'd65535, 12'd1);
                // longest nominal integration with a small dark offset
                2: set_registers(3'd5, 16'd60000, 16'd1000, 16'd20, 12'd408);
                // zero scale gives the floor, low signal below max gain always
                3: set_registers(3'd6, 16'd40000, 16'd65535, 16'd0, 12'd0);
                default: set_registers(3'($urandom_range(7)),
                                       $urandom_range(1) ? 16'(65535 - $urandom_range(200))
                                                         : 16'($urandom_range(65535, 2000)),
                                       16'($urandom_range(2000)),
                                       ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                                                : 16'($urandom_range(300)),
                                       12'($urandom_range(4095, 1)));
            endcase
            no_idle = (phase == 2);
            count   = (phase == 1) ? 60 : 170;
            k       = 0;
            while (k < count) begin
                if ($urandom_range(99) < 8) begin
                    // gain-moving run: saturate, low, saturate ... to use up retries
                    len = $urandom_range(7, 3);
                    for (j = 0; j < len; j++) begin
                        send_reading(make_reading((j % 2) ? RK_WEAK : RK_SAT));
                    end
                    k += len;
                end else begin
                    pick = $urandom_range(99);
                    if (pick < 7) begin
                        kind = RK_INVALID;
                    end else if (pick < 19) begin
                        kind = RK_SAT;
                    end else if (pick < 31) begin
                        kind = RK_WEAK;
                    end else if (pick < 51) begin
                        kind = RK_DIM;
                    end else begin
                        kind = RK_GENERAL;
                    end
                    send_reading(make_reading(kind));
                    k++;
                end
            end
            drain();
        end

        if (lux_expected.size() != 0) begin
            errors++;
            $display("%0t: results never arrived, expected %0d more, actual 0",
                     $time, lux_expected.size());
        end
        $display("run covered %0d readings over reset values and %0d register settings",
                 readings_sent, NUM_PHASES);
        $display("outcomes: accept %0d, retry %0d, saturated low gain %0d, invalid %0d, exhausted %0d",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
                 outcome_seen[4]);
        if (errors == 0) begin
            $display("light_sensor_autorange_lux verification clean");
        end else begin
            $display("light_sensor_autorange_lux verification failed");
        end
        $finish;
    end

endmodule
